[rtl/core/srpc_pkg.sv]
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared types and constants for the stepper ramp pulse controller.
// ----------------------------------------------------------------------------
package srpc_pkg;

  localparam int unsigned FreqW  = 16;
  localparam int unsigned SpeedW = 17;
  localparam int unsigned ClkW   = 24;
  localparam int unsigned CntW   = $clog2(ClkW + 1);

  localparam logic [FreqW-1:0] InitFreqRst   = FreqW'(500);
  localparam logic [FreqW-1:0] WorkFreqRst   = FreqW'(4000);
  localparam logic [FreqW-1:0] RampStepRst   = FreqW'(35);
  localparam logic [ClkW-1:0]  TimerClockRst = ClkW'(312500);

  // result transaction packing
  localparam int unsigned OutEnPos   = 0;
  localparam int unsigned OutDirPos  = 1;
  localparam int unsigned OutStepPos = 2;
  localparam int unsigned OutModeLsb = 3;
  localparam int unsigned OutFreqLsb = 5;
  localparam int unsigned OutUsedW   = OutFreqLsb + SpeedW;
  localparam int unsigned OutDataW   = 24;
  localparam int unsigned OutPadW    = OutDataW - OutUsedW;

  typedef enum logic [1:0] {
    FUNC_RAMP  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_TIMER = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_STARTING = 2'd1,
    MODE_RUNNING  = 2'd2,
    MODE_STOPPING = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    REG_START_HZ    = 2'd0,
    REG_TARGET_HZ   = 2'd1,
    REG_RAMP_STEP   = 2'd2,
    REG_TIMER_CLOCK = 2'd3
  } reg_e;

  typedef struct packed {
    logic              start;
    logic [ClkW-1:0]   dividend;
    logic [SpeedW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [ClkW-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/core/srpc_div.sv]
// ----------------------------------------------------------------------------
// srpc_div
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module srpc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srpc_pkg::div_req_t req_i,
  output srpc_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [srpc_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [srpc_pkg::SpeedW-1:0]   rem_q, rem_d;
  logic [srpc_pkg::SpeedW-1:0]   divisor_q, divisor_d;
  logic [srpc_pkg::ClkW-1:0]     quot_q, quot_d;
  logic [srpc_pkg::SpeedW:0]     shifted;
  logic [srpc_pkg::SpeedW:0]     diff;
  logic                          ge;

  always_comb begin
    shifted   = {rem_q, quot_q[srpc_pkg::ClkW-1]};
    ge        = shifted >= {1'b0, divisor_q};
    diff      = shifted - {1'b0, divisor_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    quot_d    = quot_q;
    if (busy_q) begin
      rem_d  = ge ? diff[srpc_pkg::SpeedW-1:0] : shifted[srpc_pkg::SpeedW-1:0];
      quot_d = {quot_q[srpc_pkg::ClkW-2:0], ge};
      cnt_d  = cnt_q - srpc_pkg::CntW'(1);
      if (cnt_q == srpc_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = srpc_pkg::CntW'(srpc_pkg::ClkW);
      rem_d     = '0;
      quot_d    = req_i.dividend;
      divisor_d = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    quot_q    <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[rtl/core/stepper_ramp_pulse_controller.sv]
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_controller
// Stepper driver with a linear speed ramp and a step pulse timer.
// ----------------------------------------------------------------------------
// Input stream: one event per transaction. s_axis_tuser_i carries the event
// kind (ramp tick, start, stop, timer tick), s_axis_tdata_i[0] the direction
// used by start events. Every event gives exactly one result transaction on
// the master stream: enable_n, dir_level, step_level, mode and freq_now.
// Configuration writes go through the cfg channel, always ready, and are
// expected only while no event is in flight.
// Path: events that need no new step period go from accept through the
// execute and response states. Events that program a nonzero speed (start,
// ramp ticks while starting, ramp ticks while stopping above the start
// frequency) run the shared serial divider for the period, 24 divider steps.
// Flow: the input is not ready while an event is in flight and comes back
// in the same cycle as the result is put in the output register, so no new
// event is accepted before the last one is through.
// A finished result waits in the output register; the next event is accepted
// meanwhile, and its result is held back until the receiver takes the first.
// Reset: mode idle, frequency zero, direction level high, step low, driver
// disabled, timer stopped, registers at their reset values.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // event stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] direction, [7:1] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] func
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [0] enable_n, [1] dir_level,
                                        // [2] step_level, [4:3] mode,
                                        // [21:5] freq_now, [23:22] zero
);

  localparam int unsigned SpeedW = srpc_pkg::SpeedW;
  localparam int unsigned ClkW   = srpc_pkg::ClkW;
  localparam int unsigned FreqW  = srpc_pkg::FreqW;

  logic [FreqW-1:0]  start_hz_q, start_hz_d;
  logic [FreqW-1:0]  target_hz_q, target_hz_d;
  logic [FreqW-1:0]  ramp_step_q, ramp_step_d;
  logic [ClkW-1:0]   timer_clock_q, timer_clock_d;

  srpc_pkg::state_e  state_q, state_d;
  srpc_pkg::mode_e   mode_q, mode_d;
  srpc_pkg::func_e   func_q, func_d;
  logic              dir_in_q, dir_in_d;
  logic [SpeedW-1:0] freq_q, freq_d;
  logic              dir_q, dir_d;
  logic              step_q, step_d;
  logic              enable_n_q, enable_n_d;
  logic              timer_on_q, timer_on_d;
  logic [ClkW-1:0]   period_q, period_d;
  logic [ClkW-1:0]   countdown_q, countdown_d;
  logic              m_valid_q, m_valid_d;
  logic [srpc_pkg::OutDataW-1:0] m_data_q, m_data_d;

  logic [SpeedW-1:0] ramp_ext;
  logic [SpeedW-1:0] freq_up;
  logic [SpeedW-1:0] freq_down;
  logic              out_free;

  srpc_pkg::div_req_t div_req;
  srpc_pkg::div_rsp_t div_rsp;

  srpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == srpc_pkg::ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    start_hz_d    = start_hz_q;
    target_hz_d   = target_hz_q;
    ramp_step_d   = ramp_step_q;
    timer_clock_d = timer_clock_q;
    if (cfg_valid_i) begin
      unique case (srpc_pkg::reg_e'(cfg_index_i))
        srpc_pkg::REG_START_HZ:    start_hz_d    = cfg_data_i[FreqW-1:0];
        srpc_pkg::REG_TARGET_HZ:   target_hz_d   = cfg_data_i[FreqW-1:0];
        srpc_pkg::REG_RAMP_STEP:   ramp_step_d   = cfg_data_i[FreqW-1:0];
        srpc_pkg::REG_TIMER_CLOCK: timer_clock_d = cfg_data_i[ClkW-1:0];
      endcase
    end
  end

  always_comb begin
    ramp_ext  = {1'b0, ramp_step_q};
    freq_up   = freq_q + ramp_ext;
    freq_down = (freq_q > ramp_ext) ? (freq_q - ramp_ext) : '0;
    out_free  = !m_valid_q || m_axis_tready_i;

    state_d     = state_q;
    mode_d      = mode_q;
    func_d      = func_q;
    dir_in_d    = dir_in_q;
    freq_d      = freq_q;
    dir_d       = dir_q;
    step_d      = step_q;
    enable_n_d  = enable_n_q;
    timer_on_d  = timer_on_q;
    period_d    = period_q;
    countdown_d = countdown_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;

    div_req.start    = 1'b0;
    div_req.dividend = timer_clock_q;

    unique case (state_q)
      srpc_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          func_d   = srpc_pkg::func_e'(s_axis_tuser_i);
          dir_in_d = s_axis_tdata_i[0];
          state_d  = srpc_pkg::ST_EXEC;
        end
      end
      srpc_pkg::ST_EXEC: begin
        state_d = srpc_pkg::ST_RESP;
        unique case (func_q)
          srpc_pkg::FUNC_RAMP: begin
            if (mode_q == srpc_pkg::MODE_STARTING) begin
              freq_d = freq_up;
              if (freq_up >= {1'b0, target_hz_q}) begin
                mode_d = srpc_pkg::MODE_RUNNING;
              end
              if (freq_up == '0) begin
                timer_on_d = 1'b0;
                step_d     = 1'b0;
                enable_n_d = 1'b1;
              end else begin
                div_req.start = 1'b1;
                state_d       = srpc_pkg::ST_DIV;
              end
            end else if (mode_q == srpc_pkg::MODE_STOPPING) begin
              freq_d = freq_down;
              if (freq_down <= {1'b0, start_hz_q}) begin
                timer_on_d = 1'b0;
                step_d     = 1'b0;
                enable_n_d = 1'b1;
                mode_d     = srpc_pkg::MODE_IDLE;
              end else begin
                div_req.start = 1'b1;
                state_d       = srpc_pkg::ST_DIV;
              end
            end
          end
          srpc_pkg::FUNC_START: begin
            if (mode_q == srpc_pkg::MODE_IDLE) begin
              dir_d  = dir_in_q;
              mode_d = srpc_pkg::MODE_STARTING;
              freq_d = {1'b0, start_hz_q};
              if (start_hz_q == '0) begin
                timer_on_d = 1'b0;
                step_d     = 1'b0;
                enable_n_d = 1'b1;
              end else begin
                div_req.start = 1'b1;
                state_d       = srpc_pkg::ST_DIV;
              end
            end
          end
          srpc_pkg::FUNC_STOP: begin
            if (mode_q != srpc_pkg::MODE_IDLE) begin
              mode_d = srpc_pkg::MODE_STOPPING;
            end
          end
          srpc_pkg::FUNC_TIMER: begin
            if (timer_on_q) begin
              if (countdown_q <= ClkW'(1)) begin
                step_d      = !step_q;
                countdown_d = period_q;
              end else begin
                countdown_d = countdown_q - ClkW'(1);
              end
            end
          end
        endcase
      end
      srpc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          period_d    = (div_rsp.quot == '0) ? ClkW'(1) : div_rsp.quot;
          countdown_d = period_d;
          timer_on_d  = 1'b1;
          enable_n_d  = 1'b0;
          state_d     = srpc_pkg::ST_RESP;
        end
      end
      srpc_pkg::ST_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {{srpc_pkg::OutPadW{1'b0}}, freq_q, mode_q, step_q, dir_q,
                       enable_n_q};
          state_d   = srpc_pkg::ST_IDLE;
        end
      end
    endcase

    // new frequency is the divisor
    div_req.divisor = freq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_hz_q    <= srpc_pkg::InitFreqRst;
      target_hz_q   <= srpc_pkg::WorkFreqRst;
      ramp_step_q   <= srpc_pkg::RampStepRst;
      timer_clock_q <= srpc_pkg::TimerClockRst;
      state_q       <= srpc_pkg::ST_IDLE;
      mode_q        <= srpc_pkg::MODE_IDLE;
      freq_q        <= '0;
      dir_q         <= 1'b1;
      step_q        <= 1'b0;
      enable_n_q    <= 1'b1;
      timer_on_q    <= 1'b0;
      period_q      <= '0;
      countdown_q   <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      start_hz_q    <= start_hz_d;
      target_hz_q   <= target_hz_d;
      ramp_step_q   <= ramp_step_d;
      timer_clock_q <= timer_clock_d;
      state_q       <= state_d;
      mode_q        <= mode_d;
      freq_q        <= freq_d;
      dir_q         <= dir_d;
      step_q        <= step_d;
      enable_n_q    <= enable_n_d;
      timer_on_q    <= timer_on_d;
      period_q      <= period_d;
      countdown_q   <= countdown_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    dir_in_q <= dir_in_d;
    m_data_q <= m_data_d;
  end

endmodule

[rtl/core/srpc_chk.sv]
// ----------------------------------------------------------------------------
// srpc_chk
// Port-level checks for the stepper ramp pulse controller.
// ----------------------------------------------------------------------------
module srpc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  logic       out_en_n;
  logic       out_step;
  logic [1:0] out_mode;

  assign out_en_n = m_axis_tdata_o[srpc_pkg::OutEnPos];
  assign out_step = m_axis_tdata_o[srpc_pkg::OutStepPos];
  assign out_mode = m_axis_tdata_o[srpc_pkg::OutModeLsb +: 2];

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one event in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("event accepted while busy");

  // idle means the driver is off
  a_idle_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_mode == srpc_pkg::MODE_IDLE) |-> out_en_n)
    else $error("driver enabled in idle mode");

  // disabled driver keeps the step line low
  a_disabled_step_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_en_n |-> !out_step)
    else $error("step line high while driver disabled");

endmodule

bind stepper_ramp_pulse_controller srpc_chk u_srpc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[test/stepper_ramp_pulse_controller_tb.sv]
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_controller_tb
// Event-stream testbench for the stepper ramp pulse controller. A queue-fed
// driver offers ramp, start, stop and timer events. A monitor checks every
// status transaction against an in-bench model of the ramp and step timer.
// The run covers directed corner cases and random start/ramp/stop cycles
// under several register settings, with idle gaps on both streams.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srpc_pkg::*;

  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned RandPhases   = 6;
  localparam int unsigned HalfPhase    = 128;
  localparam int unsigned MaxReports   = 10;
  localparam longint unsigned TimeoutNs = 64'd16_000_000;

  typedef struct packed {
    func_e func;
    logic  dir;
  } evt_t;

  // same layout as m_axis_tdata_o, enable_n in bit 0
  typedef struct packed {
    logic [OutPadW-1:0] pad;
    logic [SpeedW-1:0]  freq;
    mode_e              mode;
    logic               step;
    logic               dir;
    logic               en_n;
  } status_t;

  typedef struct {
    logic [FreqW-1:0] start_hz;
    logic [FreqW-1:0] target_hz;
    logic [FreqW-1:0] ramp_step;
    logic [ClkW-1:0]  timer_clk;
  } setting_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = '0;
  logic [23:0] cfg_data     = '0;
  logic        s_tvalid     = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata      = '0;
  logic [1:0]  s_tuser      = '0;
  logic        m_tvalid;
  logic        m_tready     = 1'b0;
  logic [23:0] m_tdata;

  stepper_ramp_pulse_controller i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #4 clk_i = ~clk_i;

  // register shadow
  logic [FreqW-1:0] cfg_start_hz;
  logic [FreqW-1:0] cfg_target_hz;
  logic [FreqW-1:0] cfg_ramp_step;
  logic [ClkW-1:0]  cfg_timer_clk;

  // motor model state
  mode_e             ramp_mode;
  logic [SpeedW-1:0] cmd_freq;
  logic              dir_lvl;
  logic              step_lvl;
  logic              drv_dis;
  logic              tmr_run;
  logic [ClkW-1:0]   tmr_period;
  logic [ClkW-1:0]   tmr_count;

  evt_t    evt_q[$];
  status_t status_q[$];

  int unsigned n_queued, n_events, n_results, n_settings;
  int unsigned n_starts, n_at_speed, n_toggles, mismatches;
  int unsigned src_gap, sink_gap, sink_hold, hold_asked, hold_taken;
  bit          src_jitter, sink_jitter;

  function automatic void load_speed(input logic [SpeedW-1:0] f);
    logic [ClkW-1:0] p;
    if (f == '0) begin
      tmr_run  = 1'b0;
      step_lvl = 1'b0;
      drv_dis  = 1'b1;
    end else begin
      p = cfg_timer_clk / ClkW'(f);
      if (p == '0) p = ClkW'(1);
      drv_dis    = 1'b0;
      tmr_period = p;
      tmr_count  = p;
      tmr_run    = 1'b1;
    end
  endfunction

  function automatic status_t predict_event(input evt_t e);
    status_t s;
    case (e.func)
      FUNC_RAMP: begin
        if (ramp_mode == MODE_STARTING) begin
          cmd_freq = cmd_freq + SpeedW'(cfg_ramp_step);
          load_speed(cmd_freq);
          if (cmd_freq >= SpeedW'(cfg_target_hz)) begin
            ramp_mode = MODE_RUNNING;
            n_at_speed++;
          end
        end else if (ramp_mode == MODE_STOPPING) begin
          if (cmd_freq > SpeedW'(cfg_ramp_step)) cmd_freq = cmd_freq - SpeedW'(cfg_ramp_step);
          else cmd_freq = '0;
          load_speed(cmd_freq);
          if (cmd_freq <= SpeedW'(cfg_start_hz)) begin
            load_speed('0);
            ramp_mode = MODE_IDLE;
          end
        end
      end
      FUNC_START: begin
        if (ramp_mode == MODE_IDLE) begin
          dir_lvl   = e.dir;
          ramp_mode = MODE_STARTING;
          cmd_freq  = SpeedW'(cfg_start_hz);
          load_speed(SpeedW'(cfg_start_hz));
          n_starts++;
        end
      end
      FUNC_STOP: begin
        if (ramp_mode != MODE_IDLE) ramp_mode = MODE_STOPPING;
      end
      default: begin
        if (tmr_run) begin
          if (tmr_count <= ClkW'(1)) begin
            step_lvl  = ~step_lvl;
            tmr_count = tmr_period;
            n_toggles++;
          end else begin
            tmr_count = tmr_count - 1'b1;
          end
        end
      end
    endcase
    s.pad  = '0;
    s.freq = cmd_freq;
    s.mode = ramp_mode;
    s.step = step_lvl;
    s.dir  = dir_lvl;
    s.en_n = drv_dis;
    return s;
  endfunction

  function automatic int unsigned draw_gap(input bit jitter);
    int unsigned r;
    if (!jitter) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%0t: %s", $time, msg);
  endfunction

  // event driver
  always @(posedge clk_i) begin : drive
    logic offer;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      src_gap  = 0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        status_q.push_back(predict_event(evt_q[0]));
        void'(evt_q.pop_front());
        n_events++;
        offer   = 1'b0;
        src_gap = draw_gap(src_jitter);
      end
      if (!offer) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (evt_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, evt_q[0].dir};
          s_tuser  <= evt_q[0].func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver backpressure
  always @(posedge clk_i) begin : sink
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      sink_gap  = 0;
      sink_hold = 0;
    end else if (hold_taken != hold_asked) begin
      hold_taken++;
      sink_hold = HoldCycles;
      m_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      sink_gap = draw_gap(sink_jitter);
    end
  end

  // result monitor
  always @(posedge clk_i) begin : monitor
    status_t want;
    status_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      n_results++;
      got = status_t'(m_tdata);
      if (status_q.size() == 0) begin
        note_failure($sformatf("unexpected result transaction 0x%06h", m_tdata));
      end else begin
        want = status_q.pop_front();
        if (got !== want)
          note_failure({
            $sformatf("mismatch: want en_n=%0b dir=%0b step=%0b mode=%0d freq=%0d pad=%0d,",
                      want.en_n, want.dir, want.step, want.mode, want.freq, want.pad),
            $sformatf(" got en_n=%0b dir=%0b step=%0b mode=%0d freq=%0d pad=%0d",
                      got.en_n, got.dir, got.step, got.mode, got.freq, got.pad)});
      end
    end
  end

  task automatic push_evt(input func_e f, input logic d);
    evt_t e;
    e.func = f;
    e.dir  = d;
    evt_q.push_back(e);
    n_queued++;
  endtask

  task automatic write_reg(input reg_e idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      REG_START_HZ:    cfg_start_hz  = val[FreqW-1:0];
      REG_TARGET_HZ:   cfg_target_hz = val[FreqW-1:0];
      REG_RAMP_STEP:   cfg_ramp_step = val[FreqW-1:0];
      REG_TIMER_CLOCK: cfg_timer_clk = val[ClkW-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(REG_START_HZ, 24'(s.start_hz));
    write_reg(REG_TARGET_HZ, 24'(s.target_hz));
    write_reg(REG_RAMP_STEP, 24'(s.ramp_step));
    write_reg(REG_TIMER_CLOCK, s.timer_clk);
    n_settings++;
  endtask

  // wait until the block has returned every expected result and gone quiet
  task automatic drain();
    while (evt_q.size() != 0 || status_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic setting_t random_setting();
    setting_t s;
    int unsigned init_f, step_f, work_f;
    init_f = $urandom_range(1, 3000);
    step_f = $urandom_range(1, 500);
    work_f = init_f + step_f * $urandom_range(0, 8) + $urandom_range(0, step_f - 1);
    if ($urandom_range(0, 9) == 0) work_f = $urandom_range(1, init_f);
    s.start_hz  = FreqW'(init_f);
    s.target_hz = FreqW'(work_f);
    s.ramp_step = FreqW'(step_f);
    s.timer_clk = ClkW'($urandom_range(0, 4 * work_f));
    return s;
  endfunction

  // mostly full start/ramp/stop cycles with timer ticks mixed in, some noise
  task automatic gen_random(input int unsigned target);
    int unsigned base, ups, downs, top;
    base = n_queued;
    while (n_queued - base < target) begin
      if ($urandom_range(0, 9) < 8) begin
        push_evt(FUNC_START, rand_bit());
        if (cfg_target_hz > cfg_start_hz)
          ups = (int'(cfg_target_hz) - int'(cfg_start_hz) + int'(cfg_ramp_step) - 1)
                / int'(cfg_ramp_step);
        else
          ups = 1;
        if ($urandom_range(0, 3) == 0) ups = $urandom_range(0, ups);
        repeat (ups) begin
          repeat ($urandom_range(0, 3)) push_evt(FUNC_TIMER, rand_bit());
          push_evt(FUNC_RAMP, rand_bit());
        end
        repeat ($urandom_range(0, 12)) push_evt(FUNC_TIMER, rand_bit());
        if ($urandom_range(0, 1)) push_evt(FUNC_RAMP, rand_bit());
        push_evt(FUNC_STOP, rand_bit());
        top   = int'(cfg_start_hz) + ups * int'(cfg_ramp_step);
        downs = (top - int'(cfg_start_hz)) / int'(cfg_ramp_step) + 2;
        repeat (downs) begin
          repeat ($urandom_range(0, 2)) push_evt(FUNC_TIMER, rand_bit());
          push_evt(FUNC_RAMP, rand_bit());
        end
      end else begin
        repeat ($urandom_range(1, 8))
          push_evt(func_e'($urandom_range(0, 3)), rand_bit());
      end
    end
  endtask

  initial begin : main
    setting_t s;
    cfg_start_hz  = InitFreqRst;
    cfg_target_hz = WorkFreqRst;
    cfg_ramp_step = RampStepRst;
    cfg_timer_clk = TimerClockRst;
    ramp_mode  = MODE_IDLE;
    cmd_freq   = '0;
    dir_lvl    = 1'b1;
    step_lvl   = 1'b0;
    drv_dis    = 1'b1;
    tmr_run    = 1'b0;
    tmr_period = '0;
    tmr_count  = '0;
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: idle no-ops, start/stop during ramp-up, ramp-down
    push_evt(FUNC_RAMP, 1'b0);
    push_evt(FUNC_TIMER, 1'b1);
    push_evt(FUNC_STOP, 1'b0);
    push_evt(FUNC_START, 1'b0);
    push_evt(FUNC_START, 1'b1);
    push_evt(FUNC_TIMER, 1'b0);
    push_evt(FUNC_RAMP, 1'b0);
    push_evt(FUNC_STOP, 1'b1);
    push_evt(FUNC_RAMP, 1'b0);
    push_evt(FUNC_RAMP, 1'b1);
    push_evt(FUNC_TIMER, 1'b0);
    drain();

    // zero start frequency, zero timer clock, overshoot, saturation at zero
    s = '{start_hz: '0, target_hz: 16'd5, ramp_step: 16'd3, timer_clk: '0};
    apply_setting(s);
    push_evt(FUNC_START, 1'b1);
    push_evt(FUNC_TIMER, 1'b0);
    push_evt(FUNC_RAMP, 1'b0);
    push_evt(FUNC_RAMP, 1'b1);
    push_evt(FUNC_TIMER, 1'b1);
    push_evt(FUNC_TIMER, 1'b0);
    push_evt(FUNC_RAMP, 1'b0);
    push_evt(FUNC_STOP, 1'b0);
    push_evt(FUNC_RAMP, 1'b1);
    push_evt(FUNC_RAMP, 1'b0);
    drain();

    // all registers at their maximum
    s = '{start_hz: '1, target_hz: '1, ramp_step: '1, timer_clk: '1};
    apply_setting(s);
    push_evt(FUNC_START, 1'b0);
    push_evt(FUNC_TIMER, 1'b1);
    push_evt(FUNC_RAMP, 1'b1);
    push_evt(FUNC_STOP, 1'b1);
    push_evt(FUNC_RAMP, 1'b0);
    drain();

    for (int p = 0; p < RandPhases; p++) begin
      src_jitter  = (p != 0);
      sink_jitter = (p != 0 && p != 3);
      apply_setting(random_setting());
      gen_random(HalfPhase);
      drain();
      gen_random(HalfPhase);
      if (p == 2) hold_asked++;
      drain();
    end

    $display("%0d events and %0d results over %0d register settings",
             n_events, n_results, n_settings);
    $display("%0d ramps started, %0d reached working speed, %0d step toggles",
             n_starts, n_at_speed, n_toggles);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("[stepper_ramp_pulse_controller] OK");
    end else begin
      $display("[stepper_ramp_pulse_controller] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("[stepper_ramp_pulse_controller] ERROR");
    $finish;
  end

endmodule
